// ----- hw/rtl/mpt_pkg.sv -----
// Shared types, sizes and the initial weight table of the perceptron trainer.
// Used by mpt_cell and multiclass_perceptron_trainer; depends on nothing.
package mpt_pkg;

  localparam int NUM_CLASSES  = 10;
  localparam int NUM_FEATURES = 9;
  localparam int WEIGHT_WIDTH = 16;

  localparam int LABEL_W     = 4;
  localparam int FEAT_IN_W   = 9;
  localparam int PRED_W      = 4;
  localparam int STREAK_W    = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IDX_W   = (CLS_W > LABEL_W) ? CLS_W : LABEL_W;
  localparam int SCORE_W = WEIGHT_WIDTH + $clog2(NUM_FEATURES + 1);

  localparam int INIT_ROWS = 10;
  localparam int INIT_COLS = 9;

  typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
  typedef logic signed [SCORE_W-1:0]      score_t;
  typedef logic [CLS_W-1:0]               cls_t;

  // running argmax that walks the cell chain
  typedef struct packed {
    logic   vld;
    logic   first;
    score_t best;
    cls_t   pred;
    logic   multi;
  } token_t;

  localparam weight_t W_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
  localparam weight_t W_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
  localparam longint  W_MAX_I = (64'sd1 <<< (WEIGHT_WIDTH - 1)) - 1;
  localparam longint  W_MIN_I = -W_MAX_I - 1;

  localparam int INIT_TABLE [INIT_ROWS][INIT_COLS] = '{
    '{ 0,  2,  3,  4,  5,  6,  7,  8,  9},
    '{ 2,  3,  0,  5,  6,  7,  8,  9, 10},
    '{ 3,  4,  5,  6,  7,  8,  9, 10, 11},
    '{ 4,  5,  6,  7,  8,  9, 10, 11, 12},
    '{ 5,  6,  7,  0,  9, 10, 11, 12, 13},
    '{ 6,  7,  8,  9, 17,  1,  6, 13, 14},
    '{ 7,  8,  9, 10, 11, 12, 13,  1, 15},
    '{ 8,  9, 10, 11,  9, 13, 14, 15,  1},
    '{ 9, 35, 11, 12, 13, 14, 55,  1,  2},
    '{10, 11, 12, -5, 14, 15,  1,  2,  3}
  };

  // reset weight of class c, feature k, clipped to the weight range
  function automatic weight_t init_weight(input int c, input int k);
    longint v;
    v = 0;
    if (c < INIT_ROWS && k < INIT_COLS) v = longint'(INIT_TABLE[c][k]);
    if (v > W_MAX_I) return W_MAX;
    if (v < W_MIN_I) return W_MIN;
    return weight_t'(v);
  endfunction

endpackage

// ----- hw/rtl/mpt_cell.sv -----
// One class cell: holds the weight row of its class, scores the sample,
// folds its score into the argmax token and applies the saturating update.
// Depends on mpt_pkg.
module mpt_cell
  import mpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cls_t                    idx,
  input  logic [NUM_FEATURES-1:0] act,
  input  logic                    score_en,
  input  logic                    tok_clr,
  input  logic                    tok_adv,
  input  token_t                  tok_in,
  output token_t                  tok_out,
  input  score_t                  best,
  input  logic                    upd_en,
  input  logic                    label_hit
);

  weight_t w_r   [NUM_FEATURES];
  weight_t w_nxt [NUM_FEATURES];
  score_t  score_r, score_nxt;
  token_t  tok_r, tok_nxt;
  logic    top;

  always_comb begin
    score_nxt = '0;
    for (int k = 0; k < NUM_FEATURES; k++) begin
      if (act[k]) score_nxt = score_nxt + score_t'(w_r[k]);
    end
  end

  // fold own score into the incoming token
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.first) begin
      tok_nxt.vld   = 1'b1;
      tok_nxt.first = 1'b0;
      tok_nxt.best  = score_r;
      tok_nxt.pred  = idx;
      tok_nxt.multi = 1'b0;
    end else if (tok_in.vld) begin
      if (score_r > tok_in.best) begin
        tok_nxt.best  = score_r;
        tok_nxt.pred  = idx;
        tok_nxt.multi = 1'b0;
      end else if (score_r == tok_in.best) begin
        tok_nxt.multi = 1'b1;
      end
    end
  end

  assign top = (score_r == best);

  // decrement top classes first, then increment the label row
  always_comb begin
    weight_t t;
    for (int k = 0; k < NUM_FEATURES; k++) begin
      t = w_r[k];
      if (upd_en && act[k]) begin
        if (top && t != W_MIN) t = t - weight_t'(1);
        if (label_hit && t != W_MAX) t = t + weight_t'(1);
      end
      w_nxt[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_FEATURES; k++) w_r[k] <= init_weight(int'(idx), k);
      tok_r <= '0;
    end else begin
      for (int k = 0; k < NUM_FEATURES; k++) w_r[k] <= w_nxt[k];
      if (tok_clr) begin
        tok_r <= '0;
      end else if (tok_adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_en) score_r <= score_nxt;
  end

  assign tok_out = tok_r;

endmodule

// ----- hw/rtl/multiclass_perceptron_trainer.sv -----
// Top level of the multiclass perceptron trainer: stream ports, sequencer,
// streak counter and the chain of class cells. Depends on mpt_pkg, mpt_cell.
//
//   channel | dir | tdata fields (low bit first)
//   --------+-----+-------------------------------------------------------
//   in_     | in  | label[3:0], feature_bits[12:4], zero pad
//   out_    | out | predicted[3:0], tie[4], correct[5], streak[13:6], pad
//
// An item passes through accept, score, a scan step for each cell while the
// argmax token walks the chain, then update.
// Reset loads the initial weight table into the cells.
// The update cycle waits while an earlier result has not been taken;
// one item is in work at a time.
module multiclass_perceptron_trainer
  import mpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // label[3:0], feature_bits[12:4]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // predicted, tie, correct, streak
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCORE = 4'b0010,
    S_SCAN  = 4'b0100,
    S_UPD   = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  cls_t                    cnt_r, cnt_nxt;
  logic [LABEL_W-1:0]      label_r;
  logic [NUM_FEATURES-1:0] act_r;
  logic [STREAK_W-1:0]     streak_r, streak_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [PRED_W-1:0]       pred_r;
  logic                    tie_r, correct_r;

  token_t                  tok [NUM_CLASSES];
  token_t                  seed;
  token_t                  fin;
  logic [NUM_CLASSES-1:0]  label_hit;
  logic                    in_fire, upd_fire, ok, upd_en;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign fin       = tok[NUM_CLASSES-1];
  assign ok        = !fin.multi && (IDX_W'(fin.pred) == IDX_W'(label_r));
  assign upd_fire  = (state_r == S_UPD) && (!out_vld_r || out_tready);
  assign upd_en    = upd_fire && !ok;

  always_comb begin
    seed       = '0;
    seed.vld   = (state_r == S_SCAN) && (cnt_r == '0);
    seed.first = seed.vld;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SCORE;
      end
      S_SCORE: begin
        state_nxt = S_SCAN;
        cnt_nxt   = '0;
      end
      S_SCAN: begin
        if (cnt_r == cls_t'(NUM_CLASSES - 1)) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + cls_t'(1);
        end
      end
      S_UPD: begin
        if (upd_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    streak_nxt = streak_r;
    if (upd_fire) begin
      if (!ok) begin
        streak_nxt = '0;
      end else if (streak_r != {STREAK_W{1'b1}}) begin
        streak_nxt = streak_r + STREAK_W'(1);
      end
    end
    out_vld_nxt = out_vld_r;
    if (upd_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      streak_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      streak_r  <= streak_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // sample and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      label_r <= in_tdata[LABEL_W-1:0];
      for (int k = 0; k < NUM_FEATURES; k++) begin
        act_r[k] <= (k < FEAT_IN_W) ? in_tdata[LABEL_W + (k % FEAT_IN_W)] : 1'b0;
      end
    end
    if (upd_fire) begin
      pred_r    <= PRED_W'(fin.pred);
      tie_r     <= fin.multi;
      correct_r <= ok;
    end
  end

  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
    assign label_hit[i] = (IDX_W'(label_r) == IDX_W'(i));

    mpt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (cls_t'(i)),
      .act       (act_r),
      .score_en  (state_r == S_SCORE),
      .tok_clr   (state_r == S_SCORE),
      .tok_adv   (state_r == S_SCAN),
      .tok_in    ((i == 0) ? seed : tok[(i == 0) ? 0 : i - 1]),
      .tok_out   (tok[i]),
      .best      (fin.best),
      .upd_en    (upd_en),
      .label_hit (label_hit[i])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - PRED_W - 2 - STREAK_W){1'b0}},
                       streak_r, correct_r, tie_r, pred_r};

endmodule
